// ===== sv/sal_pkg.sv =====
package sal_pkg;

   // Breakpoint table, voltage in 0.1 mV and angle in whole degrees
   localparam int NUM_POINTS = 7;
   localparam int NUM_SEGS   = NUM_POINTS - 1;
   localparam int SEG_W      = $clog2(NUM_SEGS);

   // Field widths
   localparam int VOLT_W    = 15;
   localparam int CODE_W    = 12;
   localparam int FS_W      = 9;
   localparam int ANGLE_V_W = 16;
   localparam int ANGLE_C_W = 17;
   localparam int DIFF_W    = 17;
   localparam int DEG_W     = 8;
   localparam int FRAC_W    = 8;

   // Stream payload widths, whole bytes
   localparam int REQ_W = 32;
   localparam int RSP_W = 56;

   // Pipeline depth and split
   localparam int NUM_STAGES  = 6;
   localparam int PATH_STAGES = 4;
   localparam int CMP_STAGES  = NUM_STAGES - PATH_STAGES;

   // Interpolation arithmetic
   localparam int DX_W        = 12;
   localparam int DY_W        = 14;
   localparam int T_W         = DX_W + DY_W;
   localparam int RECIP_SHIFT = T_W;
   localparam int RECIP_W     = 19;
   localparam int Q_W         = 14;
   localparam int REM_W       = 12;

   // Code scaling arithmetic
   localparam int PROD_W  = FS_W + CODE_W;
   localparam int CN_W    = PROD_W + FRAC_W;
   localparam int FOLD_W  = CN_W - CODE_W;
   localparam int Y_W     = FOLD_W + 1;
   localparam int Z_W     = CODE_W + 1;
   localparam int CROSS_W = 2 * CODE_W;
   localparam int E_W     = ANGLE_C_W + 1;

   localparam logic [CODE_W-1:0]    CODE_MAX    = 12'd4095;
   localparam logic [FS_W-1:0]      FS_RESET    = 9'd270;
   localparam logic [ANGLE_V_W-1:0] ANGLE_V_MAX = 16'd46080;

   localparam logic [VOLT_W-1:0] VOLT_POINTS [NUM_POINTS] =
      '{15'd800, 15'd4400, 15'd4900, 15'd5200, 15'd5500, 15'd5700, 15'd6100};
   localparam logic [DEG_W-1:0] ANGLE_POINTS [NUM_POINTS] =
      '{8'd0, 8'd50, 8'd70, 8'd90, 8'd110, 8'd130, 8'd180};

   // floor(2^RECIP_SHIFT / dx) per segment
   localparam logic [RECIP_W-1:0] SEG_RECIP [NUM_SEGS] = '{
      RECIP_W'((2 ** RECIP_SHIFT) / int'(VOLT_POINTS[1] - VOLT_POINTS[0])),
      RECIP_W'((2 ** RECIP_SHIFT) / int'(VOLT_POINTS[2] - VOLT_POINTS[1])),
      RECIP_W'((2 ** RECIP_SHIFT) / int'(VOLT_POINTS[3] - VOLT_POINTS[2])),
      RECIP_W'((2 ** RECIP_SHIFT) / int'(VOLT_POINTS[4] - VOLT_POINTS[3])),
      RECIP_W'((2 ** RECIP_SHIFT) / int'(VOLT_POINTS[5] - VOLT_POINTS[4])),
      RECIP_W'((2 ** RECIP_SHIFT) / int'(VOLT_POINTS[6] - VOLT_POINTS[5]))
   };

   typedef struct packed {
      logic [ANGLE_V_W-1:0] angle;
      logic [REM_W-1:0]     rem;
      logic [DX_W-1:0]      dx;
   } volt_res_type;

   typedef struct packed {
      logic [ANGLE_C_W-1:0] angle;
      logic [CODE_W-1:0]    rem;
   } code_res_type;

   function automatic logic [VOLT_W-1:0] seg_x0(input logic [SEG_W-1:0] s);
      logic [VOLT_W-1:0] r;
      r = '0;
      for (int i = 0; i < NUM_SEGS; i++) begin
         if (s == SEG_W'(i)) r = VOLT_POINTS[i];
      end
      return r;
   endfunction

   function automatic logic [DEG_W-1:0] seg_y0(input logic [SEG_W-1:0] s);
      logic [DEG_W-1:0] r;
      r = '0;
      for (int i = 0; i < NUM_SEGS; i++) begin
         if (s == SEG_W'(i)) r = ANGLE_POINTS[i];
      end
      return r;
   endfunction

   function automatic logic [DX_W-1:0] seg_dx(input logic [SEG_W-1:0] s);
      logic [DX_W-1:0] r;
      r = '0;
      for (int i = 0; i < NUM_SEGS; i++) begin
         if (s == SEG_W'(i)) r = DX_W'(VOLT_POINTS[i+1] - VOLT_POINTS[i]);
      end
      return r;
   endfunction

   // Angle step of a segment scaled by 256
   function automatic logic [DY_W-1:0] seg_dy(input logic [SEG_W-1:0] s);
      logic [DY_W-1:0] r;
      r = '0;
      for (int i = 0; i < NUM_SEGS; i++) begin
         if (s == SEG_W'(i)) r = DY_W'({ANGLE_POINTS[i+1] - ANGLE_POINTS[i], 8'd0});
      end
      return r;
   endfunction

   function automatic logic [RECIP_W-1:0] seg_recip(input logic [SEG_W-1:0] s);
      logic [RECIP_W-1:0] r;
      r = '0;
      for (int i = 0; i < NUM_SEGS; i++) begin
         if (s == SEG_W'(i)) r = SEG_RECIP[i];
      end
      return r;
   endfunction

endpackage

// ===== sv/sal_volt_path.sv =====
module sal_volt_path (
   input  logic                                 clock,
   input  logic [sal_pkg::PATH_STAGES-1:0]      stage_en,
   input  logic [sal_pkg::VOLT_W-1:0]           sample_voltage,
   output sal_pkg::volt_res_type                res
);

   // s1: segment search and offset into the segment
   logic                           lo_clamp, hi_clamp;
   logic [sal_pkg::SEG_W-1:0]      seg;
   logic [sal_pkg::SEG_W-1:0]      s1_seg_in, s1_seg_ff;
   logic [sal_pkg::DX_W-1:0]       s1_d_in, s1_d_ff;
   logic [sal_pkg::DEG_W-1:0]      s1_y0_in, s1_y0_ff;

   always_comb begin
      lo_clamp = sample_voltage <= sal_pkg::VOLT_POINTS[0];
      hi_clamp = sample_voltage >= sal_pkg::VOLT_POINTS[sal_pkg::NUM_POINTS-1];
      seg = '0;
      for (int j = 1; j < sal_pkg::NUM_POINTS - 1; j++) begin
         if (sample_voltage >= sal_pkg::VOLT_POINTS[j]) seg = sal_pkg::SEG_W'(seg + 1'b1);
      end
      s1_seg_in = seg;
      // clamped voltages sit on a breakpoint: zero offset
      s1_d_in   = (lo_clamp || hi_clamp) ? '0
                : sal_pkg::DX_W'(sample_voltage - sal_pkg::seg_x0(seg));
      s1_y0_in  = hi_clamp ? sal_pkg::ANGLE_POINTS[sal_pkg::NUM_POINTS-1]
                : sal_pkg::seg_y0(seg);
   end

   // s2: numerator t = offset * dy * 256
   logic [sal_pkg::T_W-1:0]        s2_t_in, s2_t_ff;
   logic [sal_pkg::SEG_W-1:0]      s2_seg_ff;
   logic [sal_pkg::DEG_W-1:0]      s2_y0_ff;

   assign s2_t_in = sal_pkg::T_W'(s1_d_ff * sal_pkg::seg_dy(s1_seg_ff));

   // s3: quotient estimate by reciprocal, low by at most one
   logic [sal_pkg::T_W+sal_pkg::RECIP_W-1:0] recip_prod;
   logic [sal_pkg::Q_W-1:0]        s3_q_in, s3_q_ff;
   logic [sal_pkg::T_W-1:0]        s3_t_ff;
   logic [sal_pkg::SEG_W-1:0]      s3_seg_ff;
   logic [sal_pkg::DEG_W-1:0]      s3_y0_ff;

   always_comb begin
      recip_prod = s2_t_ff * sal_pkg::seg_recip(s2_seg_ff);
      s3_q_in    = sal_pkg::Q_W'(recip_prod >> sal_pkg::RECIP_SHIFT);
   end

   // s4: remainder, one correction step, angle
   logic [sal_pkg::DX_W-1:0]       dx;
   logic [sal_pkg::T_W-1:0]        rem0;
   logic                           fix;
   sal_pkg::volt_res_type          s4_res_in, s4_res_ff;

   always_comb begin
      dx   = sal_pkg::seg_dx(s3_seg_ff);
      rem0 = sal_pkg::T_W'(s3_t_ff - sal_pkg::T_W'(s3_q_ff * dx));
      fix  = rem0 >= sal_pkg::T_W'(dx);
      s4_res_in.rem   = fix ? sal_pkg::REM_W'(rem0 - sal_pkg::T_W'(dx))
                            : sal_pkg::REM_W'(rem0);
      s4_res_in.angle = sal_pkg::ANGLE_V_W'({s3_y0_ff, 8'd0})
                      + sal_pkg::ANGLE_V_W'(s3_q_ff)
                      + sal_pkg::ANGLE_V_W'(fix);
      s4_res_in.dx    = dx;
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s1_seg_ff <= s1_seg_in;
         s1_d_ff   <= s1_d_in;
         s1_y0_ff  <= s1_y0_in;
      end
      if (stage_en[1]) begin
         s2_t_ff   <= s2_t_in;
         s2_seg_ff <= s1_seg_ff;
         s2_y0_ff  <= s1_y0_ff;
      end
      if (stage_en[2]) begin
         s3_q_ff   <= s3_q_in;
         s3_t_ff   <= s2_t_ff;
         s3_seg_ff <= s2_seg_ff;
         s3_y0_ff  <= s2_y0_ff;
      end
      if (stage_en[3]) begin
         s4_res_ff <= s4_res_in;
      end
   end

   assign res = s4_res_ff;

endmodule

// ===== sv/sal_code_path.sv =====
module sal_code_path (
   input  logic                                 clock,
   input  logic [sal_pkg::PATH_STAGES-1:0]      stage_en,
   input  logic [sal_pkg::CODE_W-1:0]           sample_code,
   input  logic [sal_pkg::FS_W-1:0]             full_scale,
   output sal_pkg::code_res_type                res
);

   // s1: full_scale * code
   logic [sal_pkg::PROD_W-1:0]     s1_p_in, s1_p_ff;

   assign s1_p_in = full_scale * sample_code;

   // s2: 4096 = 4095 + 1, so cn = hi*4095 + (hi + lo)
   logic [sal_pkg::CN_W-1:0]       cn;
   logic [sal_pkg::FOLD_W-1:0]     s2_hi_in, s2_hi_ff;
   logic [sal_pkg::Y_W-1:0]        s2_y_in, s2_y_ff;

   always_comb begin
      cn       = {s1_p_ff, 8'd0};
      s2_hi_in = cn[sal_pkg::CN_W-1:sal_pkg::CODE_W];
      s2_y_in  = sal_pkg::Y_W'(s2_hi_in) + sal_pkg::Y_W'(cn[sal_pkg::CODE_W-1:0]);
   end

   // s3: second fold leaves z below twice 4095
   logic [sal_pkg::Y_W-sal_pkg::CODE_W-1:0] hi2;
   logic [sal_pkg::ANGLE_C_W-1:0]  s3_q_in, s3_q_ff;
   logic [sal_pkg::Z_W-1:0]        s3_z_in, s3_z_ff;

   always_comb begin
      hi2     = s2_y_ff[sal_pkg::Y_W-1:sal_pkg::CODE_W];
      s3_z_in = sal_pkg::Z_W'(hi2) + sal_pkg::Z_W'(s2_y_ff[sal_pkg::CODE_W-1:0]);
      s3_q_in = sal_pkg::ANGLE_C_W'(s2_hi_ff) + sal_pkg::ANGLE_C_W'(hi2);
   end

   // s4: final compare and subtract
   logic                           wrap;
   sal_pkg::code_res_type          s4_res_in, s4_res_ff;

   always_comb begin
      wrap = s3_z_ff >= sal_pkg::Z_W'(sal_pkg::CODE_MAX);
      s4_res_in.angle = s3_q_ff + sal_pkg::ANGLE_C_W'(wrap);
      s4_res_in.rem   = wrap ? sal_pkg::CODE_W'(s3_z_ff - sal_pkg::Z_W'(sal_pkg::CODE_MAX))
                             : sal_pkg::CODE_W'(s3_z_ff);
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) s1_p_ff <= s1_p_in;
      if (stage_en[1]) begin
         s2_hi_ff <= s2_hi_in;
         s2_y_ff  <= s2_y_in;
      end
      if (stage_en[2]) begin
         s3_q_ff <= s3_q_in;
         s3_z_ff <= s3_z_in;
      end
      if (stage_en[3]) s4_res_ff <= s4_res_in;
   end

   assign res = s4_res_ff;

endmodule

// ===== sv/sal_compare.sv =====
module sal_compare (
   input  logic                                 clock,
   input  logic [sal_pkg::CMP_STAGES-1:0]       stage_en,
   input  sal_pkg::volt_res_type                volt_res,
   input  sal_pkg::code_res_type                code_res,
   output logic [sal_pkg::ANGLE_V_W-1:0]        angle_from_voltage,
   output logic [sal_pkg::ANGLE_C_W-1:0]        angle_from_code,
   output logic [sal_pkg::DIFF_W-1:0]           angle_difference
);

   // s5: sign of the fraction difference r/dx - s/4095, integer difference
   logic [sal_pkg::CROSS_W-1:0]    lhs, rhs;
   logic                           s5_lt_in, s5_lt_ff, s5_gt_in, s5_gt_ff;
   logic signed [sal_pkg::E_W-1:0] s5_e_in, s5_e_ff;
   logic [sal_pkg::ANGLE_V_W-1:0]  s5_av_ff;
   logic [sal_pkg::ANGLE_C_W-1:0]  s5_ac_ff;

   always_comb begin
      lhs      = volt_res.rem * sal_pkg::CODE_MAX;
      rhs      = code_res.rem * volt_res.dx;
      s5_lt_in = lhs < rhs;
      s5_gt_in = lhs > rhs;
      s5_e_in  = $signed(sal_pkg::E_W'(volt_res.angle)) - $signed(sal_pkg::E_W'(code_res.angle));
   end

   // s6: floor of |E + f|
   logic signed [sal_pkg::E_W-1:0] neg_e;
   logic [sal_pkg::DIFF_W-1:0]     s6_diff_in, s6_diff_ff;
   logic [sal_pkg::ANGLE_V_W-1:0]  s6_av_ff;
   logic [sal_pkg::ANGLE_C_W-1:0]  s6_ac_ff;

   always_comb begin
      neg_e = -s5_e_ff;
      if (s5_e_ff > 0) begin
         s6_diff_in = sal_pkg::DIFF_W'(s5_e_ff) - sal_pkg::DIFF_W'(s5_lt_ff);
      end else if (s5_e_ff < 0) begin
         s6_diff_in = sal_pkg::DIFF_W'(neg_e) - sal_pkg::DIFF_W'(s5_gt_ff);
      end else begin
         s6_diff_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (stage_en[0]) begin
         s5_lt_ff <= s5_lt_in;
         s5_gt_ff <= s5_gt_in;
         s5_e_ff  <= s5_e_in;
         s5_av_ff <= volt_res.angle;
         s5_ac_ff <= code_res.angle;
      end
      if (stage_en[1]) begin
         s6_diff_ff <= s6_diff_in;
         s6_av_ff   <= s5_av_ff;
         s6_ac_ff   <= s5_ac_ff;
      end
   end

   assign angle_from_voltage = s6_av_ff;
   assign angle_from_code    = s6_ac_ff;
   assign angle_difference   = s6_diff_ff;

endmodule

// ===== sv/sensor_angle_linearizer_top.sv =====
// Channel  Dir  Handshake              Payload (lowest bit first)
// req      in   req_tvalid/req_tready  sample_voltage[14:0], sample_code[26:15]
// rsp      out  rsp_tvalid/rsp_tready  angle_from_voltage[15:0], angle_from_code[32:16],
//                                      angle_difference[49:33]
// csr      in   csr_valid/csr_ready    code_full_scale_angle[8:0]
//
// One item per cycle sustained while rsp_tready stays high; six register stages,
// the deepest being the reciprocal multiply of the interpolation quotient.
// Synchronous active-high reset clears the stage valid bits and sets the
// full-scale angle to 270 degrees.
// A stalled output holds stage six; each stage moves on when its successor has
// room, so bubbles close up and the input stays ready until every stage is full.
module sensor_angle_linearizer_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [sal_pkg::REQ_W-1:0]     req_tdata,  // sample_voltage, sample_code, zero pad
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [sal_pkg::RSP_W-1:0]     rsp_tdata,  // angle_from_voltage, angle_from_code,
                                                     // angle_difference, zero pad
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [sal_pkg::FS_W-1:0]      csr_wdata   // code_full_scale_angle
);

   localparam int LAST = sal_pkg::NUM_STAGES - 1;

   logic [sal_pkg::VOLT_W-1:0]      sample_voltage;
   logic [sal_pkg::CODE_W-1:0]      sample_code;
   logic [sal_pkg::FS_W-1:0]        full_scale_in, full_scale_ff;
   logic [sal_pkg::NUM_STAGES-1:0]  valid_in, valid_ff;
   logic [sal_pkg::NUM_STAGES-1:0]  stage_en;
   sal_pkg::volt_res_type           volt_res;
   sal_pkg::code_res_type           code_res;
   logic [sal_pkg::ANGLE_V_W-1:0]   angle_from_voltage;
   logic [sal_pkg::ANGLE_C_W-1:0]   angle_from_code;
   logic [sal_pkg::DIFF_W-1:0]      angle_difference;

   assign sample_voltage = req_tdata[sal_pkg::VOLT_W-1:0];
   assign sample_code    = req_tdata[sal_pkg::VOLT_W +: sal_pkg::CODE_W];

   // The user must write the register only while idle, so no hazard with items in flight; the block does not enforce it
   assign csr_ready     = 1'b1;
   assign full_scale_in = csr_valid ? csr_wdata : full_scale_ff;

   // Stage i loads when it is empty or its successor loads
   always_comb begin
      stage_en[LAST] = !valid_ff[LAST] || rsp_tready;
      for (int i = LAST - 1; i >= 0; i--) begin
         stage_en[i] = !valid_ff[i] || stage_en[i+1];
      end
      valid_in[0] = stage_en[0] ? req_tvalid : valid_ff[0];
      for (int i = 1; i <= LAST; i++) begin
         if (stage_en[i]) valid_in[i] = valid_ff[i-1];
         else             valid_in[i] = valid_ff[i];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff      <= '0;
         full_scale_ff <= sal_pkg::FS_RESET;
      end else begin
         valid_ff      <= valid_in;
         full_scale_ff <= full_scale_in;
      end
   end

   assign req_tready = stage_en[0];
   assign rsp_tvalid = valid_ff[LAST];

   sal_volt_path u_volt (
      .clock          (clock),
      .stage_en       (stage_en[sal_pkg::PATH_STAGES-1:0]),
      .sample_voltage (sample_voltage),
      .res            (volt_res)
   );

   sal_code_path u_code (
      .clock       (clock),
      .stage_en    (stage_en[sal_pkg::PATH_STAGES-1:0]),
      .sample_code (sample_code),
      .full_scale  (full_scale_ff),
      .res         (code_res)
   );

   sal_compare u_cmp (
      .clock              (clock),
      .stage_en           (stage_en[LAST:sal_pkg::PATH_STAGES]),
      .volt_res           (volt_res),
      .code_res           (code_res),
      .angle_from_voltage (angle_from_voltage),
      .angle_from_code    (angle_from_code),
      .angle_difference   (angle_difference)
   );

   assign rsp_tdata = sal_pkg::RSP_W'({angle_difference, angle_from_code, angle_from_voltage});

`ifndef SYNTHESIS
   a_reset_empties: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("output valid after reset");

   a_accept_enters: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> valid_ff[0])
      else $error("accepted item did not enter stage one");

   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      ((&valid_ff) && !rsp_tready) |-> !req_tready)
      else $error("input ready while pipeline full and stalled");

   a_volt_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[sal_pkg::ANGLE_V_W-1:0] <= sal_pkg::ANGLE_V_MAX))
      else $error("voltage angle beyond last breakpoint angle");
`endif

endmodule
